>>> src/encoder_modbus_register_map_top_assert.svh
// Assertion macros for the encoder register map top level.
`ifndef ENCODER_MODBUS_REGISTER_MAP_TOP_ASSERT_SVH
`define ENCODER_MODBUS_REGISTER_MAP_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define EMRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define EMRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/emrm_pkg.sv
// Shared types and constants for the encoder register map.
package emrm_pkg;

	localparam int unsigned PosW = 64;
	localparam int unsigned WordW = 16;

	// Setting limits and command codes
	localparam logic [WordW-1:0] SLAVE_ID_MAX = 16'd127;
	localparam logic [WordW-1:0] BAUD_MAX = 16'd8;
	localparam logic [WordW-1:0] PARITY_MAX = 16'd3;
	localparam logic [WordW-1:0] SPEED_MAX = 16'd200;
	localparam logic [WordW-1:0] CLEAR_CODE = 16'h00ff;

	// Configuration register indexes
	localparam logic CFG_MAP_SELECT = 1'b0;
	localparam logic CFG_SINGLE_TURN_BITS = 1'b1;

	typedef enum logic [4:0] {
		RD_NONE, RD_ST_LO, RD_ST_HI, RD_MT_LO, RD_MT_HI, RD_SLAVE, RD_BAUD,
		RD_PARITY, RD_DIR, RD_PROTO, RD_UPD, RD_TOT0, RD_TOT1, RD_TOT2,
		RD_TOT3, RD_ROTDIR, RD_RPM, RD_ORIGIN, RD_SPEED
	} rd_code_t;

	typedef enum logic [3:0] {
		WR_NONE, WR_SLAVE, WR_BAUD, WR_PARITY, WR_CLEAR, WR_DIR, WR_PROTO,
		WR_UPD, WR_ORIGIN, WR_SPEED, WR_POS0, WR_POS1, WR_POS2, WR_POS3
	} wr_code_t;

	typedef enum logic [3:0] {
		CHG_NONE, CHG_SLAVE, CHG_BAUD, CHG_PARITY, CHG_DIR, CHG_PROTO,
		CHG_UPD, CHG_ORIGIN, CHG_SPEED
	} chg_code_t;

	typedef struct packed {
		rd_code_t rd;
		wr_code_t wr;
	} dec_t;

	typedef struct packed {
		logic kind;
		logic [WordW-1:0] address;
		logic [WordW-1:0] write_data;
		logic first_word;
		logic [PosW-1:0] live_position;
		logic [WordW-1:0] live_rpm;
		logic [1:0] live_direction;
	} item_t;

	typedef struct packed {
		logic [WordW-1:0] read_data;
		logic no_register;
		logic clear_request;
		logic load_request;
		logic [PosW-1:0] load_value;
		logic [3:0] setting_changed;
	} res_t;

endpackage

>>> src/emrm_decode.sv
// Address decoder for the 16-bit and 32-bit word maps.
module emrm_decode import emrm_pkg::*; (
	input logic [WordW-1:0] address,
	input logic map_select,
	output dec_t dec
);

	always_comb begin
		dec.rd = RD_NONE;
		dec.wr = WR_NONE;
		if (map_select) begin
			unique case (address)
				16'h0001: dec.rd = RD_ST_LO;
				16'h0002: dec.rd = RD_ST_HI;
				16'h0003: dec.rd = RD_MT_LO;
				16'h0004: dec.rd = RD_MT_HI;
				16'h0005: begin dec.rd = RD_SLAVE; dec.wr = WR_SLAVE; end
				16'h0006: begin dec.rd = RD_BAUD; dec.wr = WR_BAUD; end
				16'h0007: begin dec.rd = RD_PARITY; dec.wr = WR_PARITY; end
				16'h0008: dec.wr = WR_CLEAR;
				16'h0009: begin dec.rd = RD_DIR; dec.wr = WR_DIR; end
				16'h000A: begin dec.rd = RD_PROTO; dec.wr = WR_PROTO; end
				16'h000B: begin dec.rd = RD_UPD; dec.wr = WR_UPD; end
				16'h000C: dec.rd = RD_TOT3;
				16'h000D: dec.rd = RD_TOT2;
				16'h000E: dec.rd = RD_TOT1;
				16'h000F: dec.rd = RD_TOT0;
				16'h0010: dec.rd = RD_ROTDIR;
				16'h0011: dec.rd = RD_RPM;
				16'h0024: begin dec.rd = RD_ORIGIN; dec.wr = WR_ORIGIN; end
				16'h0025: begin dec.rd = RD_SPEED; dec.wr = WR_SPEED; end
				16'h0033: dec.wr = WR_POS0;
				16'h0034: dec.wr = WR_POS1;
				16'h0035: dec.wr = WR_POS2;
				16'h0036: dec.wr = WR_POS3;
				16'h0401: dec.rd = RD_TOT0;
				16'h0402: dec.rd = RD_TOT1;
				16'h0403: dec.rd = RD_TOT2;
				16'h0404: dec.rd = RD_TOT3;
				default: ;
			endcase
		end else begin
			unique case (address)
				16'h0001: dec.rd = RD_ST_LO;
				16'h0002: dec.rd = RD_MT_LO;
				16'h0003: begin dec.rd = RD_SLAVE; dec.wr = WR_SLAVE; end
				16'h0004: begin dec.rd = RD_BAUD; dec.wr = WR_BAUD; end
				16'h0005: begin dec.rd = RD_PARITY; dec.wr = WR_PARITY; end
				16'h0006: dec.wr = WR_CLEAR;
				16'h0007: begin dec.rd = RD_DIR; dec.wr = WR_DIR; end
				16'h0008: begin dec.rd = RD_PROTO; dec.wr = WR_PROTO; end
				16'h0009: begin dec.rd = RD_UPD; dec.wr = WR_UPD; end
				16'h000A: dec.rd = RD_TOT1;
				16'h000B: dec.rd = RD_TOT0;
				16'h000C: dec.rd = RD_ROTDIR;
				16'h000D: dec.rd = RD_RPM;
				16'h0024: begin dec.rd = RD_ORIGIN; dec.wr = WR_ORIGIN; end
				16'h0025: begin dec.rd = RD_SPEED; dec.wr = WR_SPEED; end
				16'h0401: dec.rd = RD_TOT0;
				16'h0402: dec.rd = RD_TOT1;
				// 16-bit map stages only the low word of each half
				16'h0033: dec.wr = WR_POS0;
				16'h0034: dec.wr = WR_POS2;
				default: ;
			endcase
		end
	end

endmodule

>>> src/emrm_core.sv
// Settings, position snapshot, staging and result formation for one word.
module emrm_core import emrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input item_t item,
	input dec_t dec,
	input logic [4:0] single_turn_bits,
	output res_t res
);

	logic [PosW-1:0] snap_q;
	logic [PosW-1:0] staged_q;
	logic [6:0] slave_id_q;
	logic [3:0] baud_q;
	logic [1:0] parity_q;
	logic [1:0] dir_q;
	logic [WordW-1:0] proto_q;
	logic [WordW-1:0] upd_q;
	logic [1:0] origin_q;
	logic [7:0] speed_q;

	logic [PosW-1:0] pos;
	logic [PosW-1:0] pos_sh;
	logic [WordW-1:0] st_mask;
	logic [WordW-1:0] v;
	logic [WordW-1:0] rdata;
	logic [PosW-1:0] staged_nxt;
	logic ok_slave, ok_baud, ok_parity, ok_dir, ok_origin, ok_speed;
	logic is_wr;

	// first word reads the live position, later words the latched one
	assign pos = item.first_word ? item.live_position : snap_q;
	assign pos_sh = pos >> single_turn_bits;
	assign st_mask = single_turn_bits[4] ? {WordW{1'b1}}
		: ~({WordW{1'b1}} << single_turn_bits[3:0]);
	assign v = item.write_data;
	assign is_wr = item.kind;

	assign ok_slave = (v != '0) && (v <= SLAVE_ID_MAX);
	assign ok_baud = (v != '0) && (v <= BAUD_MAX);
	assign ok_parity = (v != '0) && (v <= PARITY_MAX);
	assign ok_dir = (v == 16'd1) || (v == 16'd2);
	assign ok_origin = ok_dir;
	assign ok_speed = (v != '0) && (v <= SPEED_MAX);

	always_comb begin
		unique case (dec.rd)
			RD_ST_LO: rdata = pos[WordW-1:0] & st_mask;
			RD_ST_HI: rdata = pos_sh[15:0];
			RD_MT_LO: rdata = pos_sh[15:0];
			RD_MT_HI: rdata = pos_sh[31:16];
			RD_SLAVE: rdata = {9'd0, slave_id_q};
			RD_BAUD: rdata = {12'd0, baud_q};
			RD_PARITY: rdata = {14'd0, parity_q};
			RD_DIR: rdata = {14'd0, dir_q};
			RD_PROTO: rdata = proto_q;
			RD_UPD: rdata = upd_q;
			RD_TOT0: rdata = pos[15:0];
			RD_TOT1: rdata = pos[31:16];
			RD_TOT2: rdata = pos[47:32];
			RD_TOT3: rdata = pos[63:48];
			RD_ROTDIR: rdata = {14'd0, item.live_direction};
			RD_RPM: rdata = item.live_rpm;
			RD_ORIGIN: rdata = {14'd0, origin_q};
			RD_SPEED: rdata = {8'd0, speed_q};
			default: rdata = '0;
		endcase
	end

	always_comb begin
		staged_nxt = staged_q;
		unique case (dec.wr)
			WR_POS0: staged_nxt[15:0] = v;
			WR_POS1: staged_nxt[31:16] = v;
			WR_POS2: staged_nxt[47:32] = v;
			WR_POS3: staged_nxt[63:48] = v;
			default: ;
		endcase
	end

	always_comb begin
		res = '0;
		if (!is_wr) begin
			if (dec.rd == RD_NONE) res.no_register = 1'b1;
			else res.read_data = rdata;
		end else begin
			unique case (dec.wr)
				WR_NONE: res.no_register = 1'b1;
				WR_SLAVE: if (ok_slave) res.setting_changed = CHG_SLAVE;
				WR_BAUD: if (ok_baud) res.setting_changed = CHG_BAUD;
				WR_PARITY: if (ok_parity) res.setting_changed = CHG_PARITY;
				WR_CLEAR: res.clear_request = (v == CLEAR_CODE);
				WR_DIR: if (ok_dir) res.setting_changed = CHG_DIR;
				WR_PROTO: res.setting_changed = CHG_PROTO;
				WR_UPD: res.setting_changed = CHG_UPD;
				WR_ORIGIN: if (ok_origin) res.setting_changed = CHG_ORIGIN;
				WR_SPEED: if (ok_speed) res.setting_changed = CHG_SPEED;
				WR_POS3: begin
					res.load_request = 1'b1;
					res.load_value = staged_nxt;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= '0;
			staged_q <= '0;
			slave_id_q <= 7'd1;
			baud_q <= 4'd1;
			parity_q <= 2'd1;
			dir_q <= 2'd1;
			proto_q <= '0;
			upd_q <= '0;
			origin_q <= 2'd1;
			speed_q <= 8'd1;
		end else if (advance) begin
			if (item.first_word) snap_q <= item.live_position;
			if (is_wr) begin
				staged_q <= staged_nxt;
				unique case (dec.wr)
					WR_SLAVE: if (ok_slave) slave_id_q <= v[6:0];
					WR_BAUD: if (ok_baud) baud_q <= v[3:0];
					WR_PARITY: if (ok_parity) parity_q <= v[1:0];
					WR_DIR: if (ok_dir) dir_q <= v[1:0];
					WR_PROTO: proto_q <= v;
					WR_UPD: upd_q <= v;
					WR_ORIGIN: if (ok_origin) origin_q <= v[1:0];
					WR_SPEED: if (ok_speed) speed_q <= v[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

>>> src/encoder_modbus_register_map_top.sv
// Top level of the encoder holding-register map.
// Serves one 16-bit holding-register read or write per request, one request per clock
// cycle sustained. A request is captured in an input register, decoded and
// executed from there, and its result is registered in an output register.
// The input side keeps accepting while a result waits to be taken; it stalls
// only when both registers are full and the output is stalled. Configuration
// writes (map select, single-turn bit count) take effect on requests still
// waiting in the input register, so write them only while the block is idle.
`include "encoder_modbus_register_map_top_assert.svh"

module encoder_modbus_register_map_top import emrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [4:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [WordW-1:0] address,
	input logic [WordW-1:0] write_data,
	input logic first_word,
	input logic [PosW-1:0] live_position,
	input logic [WordW-1:0] live_rpm,
	input logic [1:0] live_direction,
	output logic out_valid,
	input logic out_ready,
	output logic [WordW-1:0] read_data,
	output logic no_register,
	output logic clear_request,
	output logic load_request,
	output logic [PosW-1:0] load_value,
	output logic [3:0] setting_changed
);

	logic map_select_q;
	logic [4:0] single_turn_bits_q;
	logic valid_s1;
	item_t item_s1;
	logic out_valid_q;
	res_t res_q;
	logic advance;
	dec_t dec;
	res_t res;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_select_q <= 1'b1;
			single_turn_bits_q <= 5'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAP_SELECT: map_select_q <= cfg_data[0];
				CFG_SINGLE_TURN_BITS: single_turn_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= kind;
			item_s1.address <= address;
			item_s1.write_data <= write_data;
			item_s1.first_word <= first_word;
			item_s1.live_position <= live_position;
			item_s1.live_rpm <= live_rpm;
			item_s1.live_direction <= live_direction;
		end
		if (advance) res_q <= res;
	end

	emrm_decode u_decode (
		.address(item_s1.address),
		.map_select(map_select_q),
		.dec(dec)
	);

	emrm_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(item_s1),
		.dec(dec),
		.single_turn_bits(single_turn_bits_q),
		.res(res)
	);

	assign out_valid = out_valid_q;
	assign read_data = res_q.read_data;
	assign no_register = res_q.no_register;
	assign clear_request = res_q.clear_request;
	assign load_request = res_q.load_request;
	assign load_value = res_q.load_value;
	assign setting_changed = res_q.setting_changed;

	`EMRM_ASSERT_NOW(a_err_clean, out_valid_q && res_q.no_register,
		(res_q.read_data == '0) && !res_q.clear_request && !res_q.load_request
		&& (res_q.setting_changed == '0), "error result carries other fields")
	`EMRM_ASSERT_NOW(a_load_zero, out_valid_q && !res_q.load_request,
		res_q.load_value == '0, "load value without load request")
	`EMRM_ASSERT_NOW(a_one_action, out_valid_q,
		$countones({res_q.clear_request, res_q.load_request,
		res_q.setting_changed != '0}) <= 1, "more than one action in a result")
	`EMRM_ASSERT_NOW(a_stall_cause, !in_ready,
		valid_s1 && out_valid_q && !out_ready, "input stalled without backpressure")
	`EMRM_ASSERT_NEXT(a_advance_out, advance, out_valid_q, "advanced request not presented")

endmodule

>>> sim/encoder_modbus_register_map_top_tb.sv
// Self-checking testbench for the encoder holding-register map top level.
`timescale 1ns / 1ps

module encoder_modbus_register_map_top_tb;
	import emrm_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 5;
	localparam int LATENCY = 2;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int PHASE_ITEMS = 310;
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [4:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [WordW-1:0] address;
	logic [WordW-1:0] write_data;
	logic first_word;
	logic [PosW-1:0] live_position;
	logic [WordW-1:0] live_rpm;
	logic [1:0] live_direction;
	logic out_valid;
	logic out_ready;
	logic [WordW-1:0] read_data;
	logic no_register;
	logic clear_request;
	logic load_request;
	logic [PosW-1:0] load_value;
	logic [3:0] setting_changed;

	// predictor state and configuration
	logic word32_map = 1'b1;
	logic [4:0] turn_bits = 5'd16;
	logic [63:0] snap_pos = '0;
	logic [63:0] stage_pos = '0;
	logic [6:0] node_addr = 7'd1;
	logic [3:0] baud_sel = 4'd1;
	logic [1:0] parity_sel = 2'd1;
	logic [1:0] dir_cfg = 2'd1;
	logic [15:0] proto_word = '0;
	logic [15:0] upd_period = '0;
	logic [1:0] origin_cfg = 2'd1;
	logic [7:0] speed_cfg = 8'd1;

	res_t pending_replies[$];
	int error_count = 0;
	int reply_count = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int hold_off_len = 0;
	bit idle_on = 1'b1;

	encoder_modbus_register_map_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.address(address),
		.write_data(write_data),
		.first_word(first_word),
		.live_position(live_position),
		.live_rpm(live_rpm),
		.live_direction(live_direction),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.no_register(no_register),
		.clear_request(clear_request),
		.load_request(load_request),
		.load_value(load_value),
		.setting_changed(setting_changed)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic dec_t decode_map16(input logic [15:0] a);
		dec_t d;
		d.rd = RD_NONE;
		d.wr = WR_NONE;
		case (a)
			16'h0001: d.rd = RD_ST_LO;
			16'h0002: d.rd = RD_MT_LO;
			16'h0003: begin d.rd = RD_SLAVE; d.wr = WR_SLAVE; end
			16'h0004: begin d.rd = RD_BAUD; d.wr = WR_BAUD; end
			16'h0005: begin d.rd = RD_PARITY; d.wr = WR_PARITY; end
			16'h0006: d.wr = WR_CLEAR;
			16'h0007: begin d.rd = RD_DIR; d.wr = WR_DIR; end
			16'h0008: begin d.rd = RD_PROTO; d.wr = WR_PROTO; end
			16'h0009: begin d.rd = RD_UPD; d.wr = WR_UPD; end
			16'h000A: d.rd = RD_TOT1;
			16'h000B: d.rd = RD_TOT0;
			16'h000C: d.rd = RD_ROTDIR;
			16'h000D: d.rd = RD_RPM;
			16'h0024: begin d.rd = RD_ORIGIN; d.wr = WR_ORIGIN; end
			16'h0025: begin d.rd = RD_SPEED; d.wr = WR_SPEED; end
			16'h0401: d.rd = RD_TOT0;
			16'h0402: d.rd = RD_TOT1;
			// staging in this map only reaches bits 15..0 and 47..32
			16'h0033: d.wr = WR_POS0;
			16'h0034: d.wr = WR_POS2;
			default: ;
		endcase
		return d;
	endfunction

	function automatic dec_t decode_map32(input logic [15:0] a);
		dec_t d;
		d.rd = RD_NONE;
		d.wr = WR_NONE;
		case (a)
			16'h0001: d.rd = RD_ST_LO;
			16'h0002: d.rd = RD_ST_HI;
			16'h0003: d.rd = RD_MT_LO;
			16'h0004: d.rd = RD_MT_HI;
			16'h0005: begin d.rd = RD_SLAVE; d.wr = WR_SLAVE; end
			16'h0006: begin d.rd = RD_BAUD; d.wr = WR_BAUD; end
			16'h0007: begin d.rd = RD_PARITY; d.wr = WR_PARITY; end
			16'h0008: d.wr = WR_CLEAR;
			16'h0009: begin d.rd = RD_DIR; d.wr = WR_DIR; end
			16'h000A: begin d.rd = RD_PROTO; d.wr = WR_PROTO; end
			16'h000B: begin d.rd = RD_UPD; d.wr = WR_UPD; end
			16'h000C: d.rd = RD_TOT3;
			16'h000D: d.rd = RD_TOT2;
			16'h000E: d.rd = RD_TOT1;
			16'h000F: d.rd = RD_TOT0;
			16'h0010: d.rd = RD_ROTDIR;
			16'h0011: d.rd = RD_RPM;
			16'h0024: begin d.rd = RD_ORIGIN; d.wr = WR_ORIGIN; end
			16'h0025: begin d.rd = RD_SPEED; d.wr = WR_SPEED; end
			16'h0033: d.wr = WR_POS0;
			16'h0034: d.wr = WR_POS1;
			16'h0035: d.wr = WR_POS2;
			16'h0036: d.wr = WR_POS3;
			16'h0401: d.rd = RD_TOT0;
			16'h0402: d.rd = RD_TOT1;
			16'h0403: d.rd = RD_TOT2;
			16'h0404: d.rd = RD_TOT3;
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [15:0] read_field(input rd_code_t rd, input logic [15:0] rpm,
			input logic [1:0] dir);
		logic [63:0] shifted;
		logic [63:0] w;
		shifted = snap_pos >> turn_bits;
		w = '0;
		case (rd)
			// zero turn bits: mask is empty, other slices unshifted
			RD_ST_LO: w = snap_pos & ((64'd1 << turn_bits) - 64'd1);
			RD_ST_HI, RD_MT_LO: w = shifted;
			RD_MT_HI: w = shifted >> 16;
			RD_SLAVE: w = 64'(node_addr);
			RD_BAUD: w = 64'(baud_sel);
			RD_PARITY: w = 64'(parity_sel);
			RD_DIR: w = 64'(dir_cfg);
			RD_PROTO: w = 64'(proto_word);
			RD_UPD: w = 64'(upd_period);
			RD_TOT0: w = snap_pos;
			RD_TOT1: w = snap_pos >> 16;
			RD_TOT2: w = snap_pos >> 32;
			RD_TOT3: w = snap_pos >> 48;
			RD_ROTDIR: w = 64'(dir);
			RD_RPM: w = 64'(rpm);
			RD_ORIGIN: w = 64'(origin_cfg);
			RD_SPEED: w = 64'(speed_cfg);
			default: w = '0;
		endcase
		return w[15:0];
	endfunction

	function automatic res_t predict_reply(input item_t it);
		res_t r;
		dec_t d;
		logic [15:0] v;
		r = '0;
		v = it.write_data;
		if (it.first_word)
			snap_pos = it.live_position;
		d = word32_map ? decode_map32(it.address) : decode_map16(it.address);
		if (it.kind == KIND_READ) begin
			if (d.rd == RD_NONE)
				r.no_register = 1'b1;
			else
				r.read_data = read_field(d.rd, it.live_rpm, it.live_direction);
		end else begin
			// out-of-range values are dropped silently
			case (d.wr)
				WR_NONE: r.no_register = 1'b1;
				WR_SLAVE: if (v >= 16'd1 && v <= SLAVE_ID_MAX) begin
					node_addr = v[6:0];
					r.setting_changed = CHG_SLAVE;
				end
				WR_BAUD: if (v >= 16'd1 && v <= BAUD_MAX) begin
					baud_sel = v[3:0];
					r.setting_changed = CHG_BAUD;
				end
				WR_PARITY: if (v >= 16'd1 && v <= PARITY_MAX) begin
					parity_sel = v[1:0];
					r.setting_changed = CHG_PARITY;
				end
				WR_CLEAR: r.clear_request = (v == CLEAR_CODE);
				WR_DIR: if (v == 16'd1 || v == 16'd2) begin
					dir_cfg = v[1:0];
					r.setting_changed = CHG_DIR;
				end
				WR_PROTO: begin
					proto_word = v;
					r.setting_changed = CHG_PROTO;
				end
				WR_UPD: begin
					upd_period = v;
					r.setting_changed = CHG_UPD;
				end
				WR_ORIGIN: if (v == 16'd1 || v == 16'd2) begin
					origin_cfg = v[1:0];
					r.setting_changed = CHG_ORIGIN;
				end
				WR_SPEED: if (v >= 16'd1 && v <= SPEED_MAX) begin
					speed_cfg = v[7:0];
					r.setting_changed = CHG_SPEED;
				end
				WR_POS0: stage_pos[15:0] = v;
				WR_POS1: stage_pos[31:16] = v;
				WR_POS2: stage_pos[47:32] = v;
				WR_POS3: begin
					stage_pos[63:48] = v;
					r.load_request = 1'b1;
					r.load_value = stage_pos;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [63:0] pick_position();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {1'b1, 63'd0};
			3: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [15:0] pick_setting_value();
		case ($urandom_range(0, 7))
			0: return 16'($urandom_range(0, 3));
			1: return 16'($urandom_range(0, 10));
			2: return 16'(SLAVE_ID_MAX - 16'd1 + $urandom_range(0, 2));
			3: return 16'(SPEED_MAX - 16'd1 + $urandom_range(0, 2));
			4: return 16'($urandom_range(0, 255));
			5: return 16'($urandom);
			6: return $urandom_range(0, 1) ? CLEAR_CODE : 16'hffff;
			default: return 16'($urandom_range(1, 2));
		endcase
	endfunction

	function automatic logic [15:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 16'($urandom_range(1, word32_map ? 17 : 13));
		if (r < 70)
			return 16'($urandom_range(16'h0024, 16'h0025));
		if (r < 85)
			return 16'(16'h0401 + $urandom_range(0, word32_map ? 3 : 1));
		if (r < 95)
			return 16'(16'h0033 + $urandom_range(0, 3));
		return 16'($urandom_range(0, 16'h0040));
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Leaves in_valid high on return; the caller sends again or calls wait_idle at once.
	task automatic send_word(input logic op, input logic [15:0] addr, input logic [15:0] data,
			input logic first, input logic [63:0] pos);
		item_t it;
		int gap;
		it.kind = op;
		it.address = addr;
		it.write_data = data;
		it.first_word = first;
		it.live_position = pos;
		it.live_rpm = 16'($urandom);
		it.live_direction = 2'($urandom_range(0, 3));
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		address <= it.address;
		write_data <= it.write_data;
		first_word <= it.first_word;
		live_position <= it.live_position;
		live_rpm <= it.live_rpm;
		live_direction <= it.live_direction;
		do @(posedge clk); while (!in_ready);
		pending_replies.push_back(predict_reply(it));
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_config(input logic idx, input logic [4:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_MAP_SELECT)
			word32_map = val[0];
		else
			turn_bits = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic map32, input logic [4:0] bits);
		wait_idle();
		write_config(CFG_MAP_SELECT, {4'd0, map32});
		write_config(CFG_SINGLE_TURN_BITS, bits);
	endtask

	task automatic random_request();
		int r;
		int n;
		logic [15:0] a;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			// multi-word read; later words carry fresh live data the snapshot must ignore
			n = $urandom_range(1, 4);
			a = pick_address();
			for (int k = 0; k < n; k++)
				send_word(KIND_READ, 16'(a + k), 16'($urandom), k == 0, pick_position());
		end else if (r < 55) begin
			send_word(KIND_WRITE, pick_address(), pick_setting_value(), 1'b1, pick_position());
		end else if (r < 65) begin
			n = word32_map ? 4 : 2;
			if ($urandom_range(0, 9) < 3)
				n = $urandom_range(1, n);
			for (int k = 0; k < n; k++)
				send_word(KIND_WRITE, 16'(16'h0033 + k),
					$urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom), k == 0,
					pick_position());
		end else if (r < 70) begin
			send_word(KIND_WRITE, word32_map ? 16'h0008 : 16'h0006,
				$urandom_range(0, 1) ? CLEAR_CODE : 16'($urandom_range(0, 511)), 1'b1,
				pick_position());
		end else if (r < 85) begin
			send_word(1'($urandom_range(0, 1)), pick_address(), 16'($urandom),
				1'($urandom_range(0, 1)), pick_position());
		end else begin
			send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
				1'($urandom_range(0, 1)), pick_position());
		end
	endtask

	task automatic test_settings_and_errors();
		send_word(KIND_READ, 16'h0005, 16'hffff, 1'b1, '1);
		send_word(KIND_WRITE, 16'h0005, SLAVE_ID_MAX, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0005, SLAVE_ID_MAX + 16'd1, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0006, BAUD_MAX, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0006, BAUD_MAX + 16'd1, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0007, PARITY_MAX, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0009, 16'd3, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0024, 16'd2, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0025, SPEED_MAX, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0025, SPEED_MAX + 16'd1, 1'b0, '0);
		send_word(KIND_WRITE, 16'h000A, 16'hffff, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0008, CLEAR_CODE, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0008, CLEAR_CODE - 16'd1, 1'b0, '0);
		// read-only, write-only and unmapped
		send_word(KIND_WRITE, 16'h0001, 16'hffff, 1'b0, '0);
		send_word(KIND_READ, 16'h0008, 16'h0000, 1'b0, '0);
		send_word(KIND_READ, 16'hffff, 16'h0000, 1'b1, '0);
		wait_idle();
	endtask

	task automatic test_position_slices();
		send_word(KIND_READ, 16'h0001, 16'h0000, 1'b1, 64'hfedc_ba98_7654_3210);
		send_word(KIND_READ, 16'h0004, 16'h0000, 1'b0, '0);
		send_word(KIND_READ, 16'h000C, 16'h0000, 1'b0, '0);
		send_word(KIND_READ, 16'h000F, 16'h0000, 1'b0, '0);
		wait_idle();
	endtask

	task automatic test_position_staging();
		send_word(KIND_WRITE, 16'h0033, 16'hffff, 1'b1, '1);
		send_word(KIND_WRITE, 16'h0034, 16'h0000, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0035, 16'h1234, 1'b0, '0);
		send_word(KIND_WRITE, 16'h0036, 16'hffff, 1'b0, '0);
		wait_idle();
	endtask

	task automatic test_word16_map();
		set_mode(1'b0, 5'd16);
		send_word(KIND_WRITE, 16'h0033, 16'hffff, 1'b1, 64'h0123_4567_89ab_cdef);
		send_word(KIND_WRITE, 16'h0034, 16'ha5a5, 1'b0, '0);
		send_word(KIND_READ, 16'h0002, 16'h0000, 1'b0, '0);
		send_word(KIND_READ, 16'h000A, 16'h0000, 1'b0, '0);
		wait_idle();
	endtask

	task automatic test_single_turn_edges();
		set_mode(1'b1, 5'd0);
		send_word(KIND_READ, 16'h0001, 16'h0000, 1'b1, '1);
		send_word(KIND_READ, 16'h0002, 16'h0000, 1'b0, '0);
		set_mode(1'b1, 5'd31);
		send_word(KIND_READ, 16'h0004, 16'h0000, 1'b1, '1);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int target;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_mode(1'b1, 5'd1);
				1: set_mode(1'b0, 5'd31);
				default: set_mode(1'($urandom_range(0, 1)), 5'($urandom_range(1, 31)));
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 49) == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				random_request();
			end
		end
		idle_on = 1'b1;
		wait_idle();
	endtask

	// Output held off while requests keep coming, so the input side must stall.
	task automatic test_back_pressure();
		wait_idle();
		idle_on = 1'b0;
		hold_off_len = HOLD_OFF_CYCLES;
		wait (hold_off_len == 0);
		for (int k = 0; k < 24; k++)
			send_word(1'($urandom_range(0, 1)), pick_address(), pick_setting_value(), k == 0,
				pick_position());
		idle_on = 1'b1;
		wait_idle();
	endtask

	initial begin
		int stall;
		int run;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_len > 0) begin
				stall = hold_off_len;
				hold_off_len = 0;
			end else begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			if (!idle_on)
				run = 16;
			else if ($urandom_range(0, 9) == 0)
				run = $urandom_range(20, 60);
			else
				run = $urandom_range(1, 8);
			repeat (run) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				report_error("result with no request pending");
			end else begin
				want = pending_replies.pop_front();
				if (read_data !== want.read_data)
					report_error($sformatf("reply %0d read_data %h, want %h",
						reply_count, read_data, want.read_data));
				if (no_register !== want.no_register)
					report_error($sformatf("reply %0d no_register %b, want %b",
						reply_count, no_register, want.no_register));
				if (clear_request !== want.clear_request)
					report_error($sformatf("reply %0d clear_request %b, want %b",
						reply_count, clear_request, want.clear_request));
				if (load_request !== want.load_request)
					report_error($sformatf("reply %0d load_request %b, want %b",
						reply_count, load_request, want.load_request));
				if (load_value !== want.load_value)
					report_error($sformatf("reply %0d load_value %h, want %h",
						reply_count, load_value, want.load_value));
				if (setting_changed !== want.setting_changed)
					report_error($sformatf("reply %0d setting_changed %0d, want %0d",
						reply_count, setting_changed, want.setting_changed));
			end
			reply_count++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("encoder_modbus_register_map_top_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MAP_SELECT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_READ;
		address <= '0;
		write_data <= '0;
		first_word <= 1'b0;
		live_position <= '0;
		live_rpm <= '0;
		live_direction <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_settings_and_errors();
		test_position_slices();
		test_position_staging();
		test_word16_map();
		test_single_turn_edges();
		test_random_traffic();
		test_back_pressure();

		wait_idle();
		repeat (LATENCY + 8) @(posedge clk);
		if (error_count == 0 && pending_replies.size() == 0)
			$display("encoder_modbus_register_map_top_tb: done, clean");
		else
			$display("encoder_modbus_register_map_top_tb: done, errors");
		$finish;
	end

endmodule
